/* hdl/swpv_pkg.sv */
// ----------------------------------------------------------------------------
// swpv_pkg
// Shared types and constants for the sliding window price/volume unit.
// ----------------------------------------------------------------------------
package swpv_pkg;

  // Default number of trades held in the window.
  localparam int unsigned DefaultWindow = 20;

  // Fixed payload widths.
  localparam int unsigned PriceW = 32;
  localparam int unsigned VolW   = 32;
  localparam int unsigned TotW   = 37;
  localparam int unsigned CountW = 5;

  // Largest value a count output can show.
  localparam int unsigned CountMax = 31;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_NEW,
    ST_ADD,
    ST_FIND_OLD,
    ST_SUB,
    ST_HOLD
  } state_t;

  // Control from the sequencer to the price table.
  typedef struct packed {
    logic lookup;
    logic wr_en;
    logic set_valid;
    logic clr_valid;
  } tbl_cmd_t;

endpackage

/* hdl/sliding_window_price_volume_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_price_volume_unit
// Windowed volume-by-price table with eviction of the oldest trade.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (price, volume) enter on in_valid/in_ready; one result per
//   request leaves on out_valid/out_ready. Each trade is added to the total
//   for its price and stored in a ring of the last WINDOW trades; once the
//   ring is full, the oldest trade is evicted and subtracted from its price.
//   Each request passes through the sequencer states in order: the idle
//   state that accepts it, then two key matches, each followed by a
//   read-modify-write of the total memory; a new request is accepted only
//   once the sequencer is back in the idle state.
//   A result sits in the output register while the next request is being
//   processed; if the receiver still stalls when the next result is ready,
//   the sequencer holds it and accepts nothing until the register frees.
//   Reset empties the ring and the table at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module sliding_window_price_volume_unit #(
  parameter int unsigned WINDOW = swpv_pkg::DefaultWindow
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [swpv_pkg::PriceW-1:0]   price,
  input  logic [swpv_pkg::VolW-1:0]     volume,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [swpv_pkg::TotW-1:0]     total_at_price,
  output logic                          evicted,
  output logic [swpv_pkg::PriceW-1:0]   evicted_price,
  output logic [swpv_pkg::VolW-1:0]     evicted_volume,
  output logic [swpv_pkg::TotW-1:0]     evicted_price_total,
  output logic [swpv_pkg::CountW-1:0]   distinct_prices,
  output logic [swpv_pkg::CountW-1:0]   window_fill
);

  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned IdxW  = $clog2(WINDOW + 1);
  localparam int unsigned UseW  = $clog2(WINDOW + 2);
  localparam int unsigned SumW  = FillW + 1;
  localparam int unsigned TotW  = swpv_pkg::TotW;

  swpv_pkg::state_t   state;
  swpv_pkg::state_t   state_next;
  swpv_pkg::tbl_cmd_t tcmd;

  // Request registers and ring state.
  logic [swpv_pkg::PriceW-1:0] p_r;
  logic [swpv_pkg::VolW-1:0]   v_r;
  logic                        ev_r;
  logic [SlotW-1:0]            oldest_slot;
  logic [FillW-1:0]            fill_count;
  logic [TotW-1:0]             sum_r;
  logic [IdxW-1:0]             new_idx;

  // Held result.
  logic [TotW-1:0]             res_tot;
  logic                        res_ev;
  logic [swpv_pkg::PriceW-1:0] res_ep;
  logic [swpv_pkg::VolW-1:0]   res_ev_vol;
  logic [TotW-1:0]             res_ep_tot;
  logic [UseW-1:0]             res_used;
  logic [FillW-1:0]            res_fill;

  // Ring and table connections.
  logic [swpv_pkg::PriceW-1:0] ring_price;
  logic [swpv_pkg::VolW-1:0]   ring_volume;
  logic                        ring_wr;
  logic [SlotW-1:0]            ring_slot;
  logic [swpv_pkg::PriceW-1:0] tkey;
  logic                        t_hit;
  logic                        t_found;
  logic [IdxW-1:0]             t_idx;
  logic [TotW-1:0]             t_rd;
  logic [TotW-1:0]             t_wr;
  logic [UseW-1:0]             t_used;

  // Arithmetic of the two update steps.
  logic [TotW-1:0]             add_sum;
  logic [TotW-1:0]             sub_rem;
  logic                        sub_do;
  logic [SumW-1:0]             slot_sum;
  logic [TotW-1:0]             c_tot;
  logic [TotW-1:0]             c_ep_tot;
  logic [UseW-1:0]             c_used;
  logic [FillW-1:0]            c_fill;
  logic                        load_out;

  swpv_ring #(.WINDOW(WINDOW)) u_ring (
    .clk       (clk),
    .wr_en     (ring_wr),
    .wr_addr   (ring_slot),
    .wr_price  (p_r),
    .wr_volume (v_r),
    .rd_addr   (oldest_slot),
    .rd_price  (ring_price),
    .rd_volume (ring_volume)
  );

  swpv_table #(.WINDOW(WINDOW)) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tcmd),
    .key      (tkey),
    .wr_idx   (t_idx),
    .wr_total (t_wr),
    .hit      (t_hit),
    .found    (t_found),
    .idx      (t_idx),
    .rd_total (t_rd),
    .used     (t_used)
  );

  // Datapath for the add and subtract steps.
  always_comb begin
    add_sum  = (t_hit ? t_rd : '0) + TotW'(v_r);
    sub_do   = ev_r && t_hit;
    sub_rem  = (t_rd > TotW'(ring_volume)) ? (t_rd - TotW'(ring_volume)) : '0;
    slot_sum = SumW'(oldest_slot) + SumW'(fill_count);
    if (ev_r) begin
      ring_slot = oldest_slot;
    end else if (slot_sum >= SumW'(WINDOW)) begin
      ring_slot = SlotW'(slot_sum - SumW'(WINDOW));
    end else begin
      ring_slot = SlotW'(slot_sum);
    end
    if (sub_do && (t_idx == new_idx)) begin
      c_tot = sub_rem;
    end else begin
      c_tot = sum_r;
    end
    c_ep_tot = sub_do ? sub_rem : '0;
    c_used   = (sub_do && (sub_rem == '0)) ? (t_used - UseW'(1)) : t_used;
    c_fill   = ev_r ? fill_count : (fill_count + FillW'(1));
    load_out = !out_valid || out_ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      swpv_pkg::ST_IDLE:     if (in_valid) state_next = swpv_pkg::ST_FIND_NEW;
      swpv_pkg::ST_FIND_NEW: state_next = swpv_pkg::ST_ADD;
      swpv_pkg::ST_ADD:      state_next = swpv_pkg::ST_FIND_OLD;
      swpv_pkg::ST_FIND_OLD: state_next = swpv_pkg::ST_SUB;
      swpv_pkg::ST_SUB:      state_next = load_out ? swpv_pkg::ST_IDLE : swpv_pkg::ST_HOLD;
      swpv_pkg::ST_HOLD:     if (load_out) state_next = swpv_pkg::ST_IDLE;
      default:               state_next = swpv_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    ring_wr  = 1'b0;
    tcmd     = '0;
    tkey     = p_r;
    t_wr     = add_sum;
    case (state)
      swpv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      swpv_pkg::ST_FIND_NEW: begin
        tcmd.lookup = 1'b1;
      end
      swpv_pkg::ST_ADD: begin
        tcmd.wr_en     = t_found;
        tcmd.set_valid = !t_hit && t_found;
      end
      swpv_pkg::ST_FIND_OLD: begin
        tkey        = ring_price;
        tcmd.lookup = 1'b1;
      end
      swpv_pkg::ST_SUB: begin
        t_wr           = sub_rem;
        tcmd.wr_en     = sub_do;
        tcmd.clr_valid = sub_do && (sub_rem == '0);
        ring_wr        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= swpv_pkg::ST_IDLE;
      oldest_slot <= '0;
      fill_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == swpv_pkg::ST_SUB) begin
        fill_count <= c_fill;
        if (ev_r) begin
          oldest_slot <= (SumW'(oldest_slot) + SumW'(1) >= SumW'(WINDOW)) ? '0
                         : oldest_slot + SlotW'(1);
        end
      end
      if (((state == swpv_pkg::ST_SUB) || (state == swpv_pkg::ST_HOLD)) && load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and step payload registers.
  always_ff @(posedge clk) begin
    if (state == swpv_pkg::ST_IDLE && in_valid) begin
      p_r  <= price;
      v_r  <= volume;
      ev_r <= (fill_count >= FillW'(WINDOW));
    end
    if (state == swpv_pkg::ST_ADD) begin
      sum_r   <= add_sum;
      new_idx <= t_idx;
    end
    if (state == swpv_pkg::ST_SUB) begin
      res_tot    <= c_tot;
      res_ev     <= ev_r;
      res_ep     <= ev_r ? ring_price : '0;
      res_ev_vol <= ev_r ? ring_volume : '0;
      res_ep_tot <= c_ep_tot;
      res_used   <= c_used;
      res_fill   <= c_fill;
    end
  end

  // Output register; counts saturate at the port width.
  always_ff @(posedge clk) begin
    if (state == swpv_pkg::ST_SUB && load_out) begin
      total_at_price      <= c_tot;
      evicted             <= ev_r;
      evicted_price       <= ev_r ? ring_price : '0;
      evicted_volume      <= ev_r ? ring_volume : '0;
      evicted_price_total <= c_ep_tot;
      distinct_prices     <= (32'(c_used) > swpv_pkg::CountMax) ? '1
                             : swpv_pkg::CountW'(c_used);
      window_fill         <= (32'(c_fill) > swpv_pkg::CountMax) ? '1
                             : swpv_pkg::CountW'(c_fill);
    end else if (state == swpv_pkg::ST_HOLD && load_out) begin
      total_at_price      <= res_tot;
      evicted             <= res_ev;
      evicted_price       <= res_ep;
      evicted_volume      <= res_ev_vol;
      evicted_price_total <= res_ep_tot;
      distinct_prices     <= (32'(res_used) > swpv_pkg::CountMax) ? '1
                             : swpv_pkg::CountW'(res_used);
      window_fill         <= (32'(res_fill) > swpv_pkg::CountMax) ? '1
                             : swpv_pkg::CountW'(res_fill);
    end
  end

endmodule

/* hdl/swpv_ring.sv */
// ----------------------------------------------------------------------------
// swpv_ring
// Trade ring memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module swpv_ring #(
  parameter int unsigned WINDOW = swpv_pkg::DefaultWindow
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] wr_addr,
  input  logic [swpv_pkg::PriceW-1:0]                   wr_price,
  input  logic [swpv_pkg::VolW-1:0]                     wr_volume,
  input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] rd_addr,
  output logic [swpv_pkg::PriceW-1:0]                   rd_price,
  output logic [swpv_pkg::VolW-1:0]                     rd_volume
);

  localparam int unsigned DataW = swpv_pkg::PriceW + swpv_pkg::VolW;

  logic [DataW-1:0] mem [WINDOW];
  logic [DataW-1:0] rd_data;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_price, wr_volume};
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign rd_price  = rd_data[DataW-1:swpv_pkg::VolW];
  assign rd_volume = rd_data[swpv_pkg::VolW-1:0];

endmodule

/* hdl/swpv_table.sv */
// ----------------------------------------------------------------------------
// swpv_table
// Price table: key match over the stored prices, a total memory with a
// registered read, valid bits and a count of occupied entries.
// ----------------------------------------------------------------------------
module swpv_table #(
  parameter int unsigned WINDOW = swpv_pkg::DefaultWindow
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swpv_pkg::tbl_cmd_t                    cmd,
  input  logic [swpv_pkg::PriceW-1:0]           key,
  input  logic [$clog2(WINDOW+1)-1:0]           wr_idx,
  input  logic [swpv_pkg::TotW-1:0]             wr_total,
  output logic                                  hit,
  output logic                                  found,
  output logic [$clog2(WINDOW+1)-1:0]           idx,
  output logic [swpv_pkg::TotW-1:0]             rd_total,
  output logic [$clog2(WINDOW+2)-1:0]           used
);

  localparam int unsigned Depth = WINDOW + 1;
  localparam int unsigned IdxW  = $clog2(WINDOW + 1);
  localparam int unsigned UseW  = $clog2(WINDOW + 2);

  logic [swpv_pkg::PriceW-1:0] price [Depth];
  logic [Depth-1:0]            valid;
  logic [swpv_pkg::TotW-1:0]   mem [Depth];

  logic            m_hit;
  logic [IdxW-1:0] m_idx;
  logic            f_any;
  logic [IdxW-1:0] f_idx;
  logic [IdxW-1:0] rd_addr;

  // Match the key against every entry; also find the first free entry.
  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    f_any = 1'b0;
    f_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (valid[i] && (price[i] == key) && !m_hit) begin
        m_hit = 1'b1;
        m_idx = IdxW'(i);
      end
      if (!valid[i] && !f_any) begin
        f_any = 1'b1;
        f_idx = IdxW'(i);
      end
    end
    rd_addr = m_hit ? m_idx : f_idx;
  end

  // Latch the lookup outcome.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit   <= m_hit;
      found <= m_hit | f_any;
      idx   <= rd_addr;
    end
  end

  // Total memory.
  always_ff @(posedge clk) begin
    rd_total <= mem[rd_addr];
    if (cmd.wr_en) begin
      mem[wr_idx] <= wr_total;
    end
  end

  // Stored keys for newly occupied entries.
  always_ff @(posedge clk) begin
    if (cmd.set_valid) begin
      price[wr_idx] <= key;
    end
  end

  // Occupancy bits and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      used  <= '0;
    end else if (cmd.set_valid) begin
      valid[wr_idx] <= 1'b1;
      used          <= used + UseW'(1);
    end else if (cmd.clr_valid) begin
      valid[wr_idx] <= 1'b0;
      used          <= used - UseW'(1);
    end
  end

endmodule

/* hdl/swpv_checker.sv */
// ----------------------------------------------------------------------------
// swpv_checker
// Port-level checks for the sliding window price/volume unit.
// ----------------------------------------------------------------------------
module swpv_checker #(
  parameter int unsigned WINDOW = swpv_pkg::DefaultWindow
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [swpv_pkg::TotW-1:0]   total_at_price,
  input logic                        evicted,
  input logic [swpv_pkg::PriceW-1:0] evicted_price,
  input logic [swpv_pkg::VolW-1:0]   evicted_volume,
  input logic [swpv_pkg::TotW-1:0]   evicted_price_total,
  input logic [swpv_pkg::CountW-1:0] distinct_prices,
  input logic [swpv_pkg::CountW-1:0] window_fill
);

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_at_price) && $stable(evicted))
    else $error("result changed while stalled");

  // No eviction means empty eviction fields.
  a_noev: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_price == '0 && evicted_volume == '0
      && evicted_price_total == '0)
    else $error("eviction fields set without eviction");

  // An eviction happens only with a full window.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> 32'(window_fill) == ((WINDOW > 31) ? 31 : WINDOW))
    else $error("eviction before window filled");

  // Every result follows a trade, so the window is never empty. The table can
  // be empty when an eviction frees the entry of the incoming price.
  a_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_fill != '0)
    else $error("empty window after a trade");

  // Reset drops any pending result.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_price_volume_unit swpv_checker #(.WINDOW(WINDOW)) u_swpv_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .total_at_price      (total_at_price),
  .evicted             (evicted),
  .evicted_price       (evicted_price),
  .evicted_volume      (evicted_volume),
  .evicted_price_total (evicted_price_total),
  .distinct_prices     (distinct_prices),
  .window_fill         (window_fill)
);
